// ===== design/saes_pkg.sv =====
package saes_pkg;

  localparam int unsigned BlockW = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [3:0] nibble_t;
  typedef logic [7:0] word_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CIPHER_KEY   = 2'd0,
    CFG_INIT_VECTOR  = 2'd1,
    CFG_DECRYPT_MODE = 2'd2,
    CFG_CHAIN_ENABLE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    block_t k1;
    block_t k2;
  } round_keys_t;

  localparam nibble_t SBOX_FWD [16] = '{
    4'h9, 4'h4, 4'ha, 4'hb, 4'hd, 4'h1, 4'h8, 4'h5,
    4'h6, 4'h2, 4'h0, 4'h3, 4'hc, 4'he, 4'hf, 4'h7
  };
  localparam nibble_t SBOX_INV [16] = '{
    4'ha, 4'h5, 4'h9, 4'hb, 4'h1, 4'h7, 4'h8, 4'hf,
    4'h6, 4'h0, 4'h2, 4'h3, 4'hc, 4'h4, 4'hd, 4'he
  };

  localparam word_t RCON_1 = 8'h80;
  localparam word_t RCON_2 = 8'h30;

  // Matrix entries: the diagonal and the off-diagonal coefficient.
  localparam nibble_t MIX_FWD_DIAG = 4'h1;
  localparam nibble_t MIX_FWD_OFF  = 4'h4;
  localparam nibble_t MIX_INV_DIAG = 4'h9;
  localparam nibble_t MIX_INV_OFF  = 4'h2;

  // GF(16) multiply modulo x^4 + x + 1.
  function automatic nibble_t gf_mul(nibble_t a, nibble_t b);
    nibble_t r;
    nibble_t x;
    r = '0;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) begin
        r = r ^ x;
      end
      x = x[3] ? ({x[2:0], 1'b0} ^ 4'h3) : {x[2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic block_t sub_nibbles(block_t v, logic inv);
    block_t r;
    for (int i = 0; i < 4; i++) begin
      r[4*i +: 4] = inv ? SBOX_INV[v[4*i +: 4]] : SBOX_FWD[v[4*i +: 4]];
    end
    return r;
  endfunction

  // Row-major layout: the second row is nibbles 2 and 3, which swap.
  function automatic block_t shift_rows(block_t v);
    return {v[15:8], v[3:0], v[7:4]};
  endfunction

  // Columns are nibbles (0,2) and (1,3), nibble 0 the most significant.
  function automatic block_t mix_columns(block_t v, logic inv);
    nibble_t d;
    nibble_t o;
    d = inv ? MIX_INV_DIAG : MIX_FWD_DIAG;
    o = inv ? MIX_INV_OFF : MIX_FWD_OFF;
    return {gf_mul(v[15:12], d) ^ gf_mul(v[7:4], o),
            gf_mul(v[11:8], d) ^ gf_mul(v[3:0], o),
            gf_mul(v[15:12], o) ^ gf_mul(v[7:4], d),
            gf_mul(v[11:8], o) ^ gf_mul(v[3:0], d)};
  endfunction

  function automatic word_t rot_sub(word_t w);
    return {SBOX_FWD[w[3:0]], SBOX_FWD[w[7:4]]};
  endfunction

  function automatic round_keys_t expand_key(block_t key);
    round_keys_t rk;
    word_t w2;
    word_t w3;
    word_t w4;
    w2 = key[15:8] ^ RCON_1 ^ rot_sub(key[7:0]);
    w3 = w2 ^ key[7:0];
    w4 = w2 ^ RCON_2 ^ rot_sub(w3);
    rk.k1 = {w2, w3};
    rk.k2 = {w4, w4 ^ w3};
    return rk;
  endfunction

  function automatic block_t encrypt_block(block_t p, block_t k0, round_keys_t rk);
    block_t s;
    s = p ^ k0;
    s = mix_columns(shift_rows(sub_nibbles(s, 1'b0)), 1'b0) ^ rk.k1;
    s = shift_rows(sub_nibbles(s, 1'b0)) ^ rk.k2;
    return s;
  endfunction

  function automatic block_t decrypt_block(block_t c, block_t k0, round_keys_t rk);
    block_t s;
    s = c ^ rk.k2;
    s = sub_nibbles(shift_rows(s), 1'b1) ^ rk.k1;
    s = mix_columns(s, 1'b1);
    s = sub_nibbles(shift_rows(s), 1'b1) ^ k0;
    return s;
  endfunction

endpackage

// ===== design/saes_stream_if.sv =====
interface saes_in_if;
  logic                   valid;
  logic                   ready;
  saes_pkg::block_t       data_in;
  logic                   first_block;

  modport source (output valid, output data_in, output first_block, input ready);
  modport sink (input valid, input data_in, input first_block, output ready);
endinterface

interface saes_out_if;
  logic                   valid;
  logic                   ready;
  saes_pkg::block_t       data_out;

  modport source (output valid, output data_out, input ready);
  modport sink (input valid, input data_out, output ready);
endinterface

// ===== design/simplified_aes_cbc_cipher_unit.sv =====
// Two-round simplified AES on 16-bit blocks with optional CBC chaining. The
// block accepts one transaction per clock cycle unless the output stalls on
// out_ch_o.ready. Each transaction sits in the input register while the cipher
// works on it, and the result enters the output register as the output side
// advances. The rate is set by the chain register: when encrypting its next
// value is the cipher result itself, so the whole cipher sits in the single
// loop from the chain register back to itself. A transaction with first_block
// set reloads the chain from init_vector before it is used; until then the
// chain starts at zero. With chaining off, the chain is still tracked so that
// chaining can be switched on later. Configuration registers are written
// through the plain write port, only while the block is idle (kept by the
// user, not the block); a new key becomes registered round keys next cycle.
module simplified_aes_cbc_cipher_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [saes_pkg::CfgIdxW-1:0] cfg_index_i,
  input  saes_pkg::block_t         cfg_data_i,
  saes_in_if.sink                  in_ch_i,
  saes_out_if.source               out_ch_o
);

  // Configuration registers.
  saes_pkg::block_t cipher_key_q;
  saes_pkg::block_t init_vector_q;
  logic             decrypt_mode_q;
  logic             chain_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_key_q   <= '0;
      init_vector_q  <= '0;
      decrypt_mode_q <= 1'b0;
      chain_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (saes_pkg::cfg_idx_e'(cfg_index_i))
        saes_pkg::CFG_CIPHER_KEY:   cipher_key_q   <= cfg_data_i;
        saes_pkg::CFG_INIT_VECTOR:  init_vector_q  <= cfg_data_i;
        saes_pkg::CFG_DECRYPT_MODE: decrypt_mode_q <= cfg_data_i[0];
        saes_pkg::CFG_CHAIN_ENABLE: chain_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The round keys depend only on the key register, so they are expanded once
  // per cycle into a register. A transaction accepted right after a key write
  // reaches the cipher from the input register, when the new round keys are in place.
  saes_pkg::round_keys_t round_keys_q;

  always_ff @(posedge clk_i) begin
    round_keys_q <= saes_pkg::expand_key(cipher_key_q);
  end

  // Input register. The output side takes a new result whenever the output
  // register is empty or its result is being taken in this cycle, and the
  // input register then moves on, so a transaction can enter every cycle.
  logic             in_valid_q;
  saes_pkg::block_t in_data_q;
  logic             in_first_q;
  logic             out_valid_q;
  saes_pkg::block_t out_data_q;
  logic             out_advance;
  logic             in_advance;

  assign out_advance    = !out_valid_q || out_ch_o.ready;
  assign in_advance     = !in_valid_q || out_advance;
  assign in_ch_i.ready  = in_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_advance) begin
      in_valid_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_advance && in_ch_i.valid) begin
      in_data_q  <= in_ch_i.data_in;
      in_first_q <= in_ch_i.first_block;
    end
  end

  // Cipher and chaining. The chain register holds the previous ciphertext
  // block: the result when encrypting, the incoming block when decrypting.
  saes_pkg::block_t chain_q;
  saes_pkg::block_t chain_base;
  saes_pkg::block_t chain_mask;
  saes_pkg::block_t enc_result;
  saes_pkg::block_t dec_result;
  saes_pkg::block_t result_d;
  saes_pkg::block_t chain_d;

  always_comb begin
    chain_base = in_first_q ? init_vector_q : chain_q;
    chain_mask = chain_enable_q ? chain_base : '0;
    enc_result = saes_pkg::encrypt_block(in_data_q ^ chain_mask, cipher_key_q, round_keys_q);
    dec_result = saes_pkg::decrypt_block(in_data_q, cipher_key_q, round_keys_q) ^ chain_mask;
    result_d   = decrypt_mode_q ? dec_result : enc_result;
    chain_d    = decrypt_mode_q ? in_data_q : enc_result;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (out_advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        chain_q <= chain_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_advance && in_valid_q) begin
      out_data_q <= result_d;
    end
  end

  assign out_ch_o.valid    = out_valid_q;
  assign out_ch_o.data_out = out_data_q;

endmodule
